@@ hw/rtl/bpc_pkg.sv @@
// Shared types, constants and helpers of the pressure compensation unit.
package bpc_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 64;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgCalibA = 2'd0,
    CfgCalibB = 2'd1,
    CfgCalibC = 2'd2
  } cfg_idx_e;

  localparam logic [31:0] TempOffset = 32'd4000;
  localparam logic [31:0] B4Offset   = 32'd32768;
  localparam logic [31:0] PressScale = 32'd50000;
  localparam logic [31:0] PCoefSq    = 32'd3038;
  localparam logic [31:0] PCoefLin   = 32'hFFFF_E343; // -7357
  localparam logic [31:0] PCoefOff   = 32'd3791;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [15:0] raw_pressure;
  } bpc_in_t;

  typedef struct packed {
    logic signed [31:0] temperature_tenths;
    logic signed [31:0] pressure_pascal;
    logic               divide_error;
  } bpc_out_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] zx16(input logic [15:0] v);
    return {16'd0, v};
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
    logic signed [31:0] sv;
    sv = $signed(v);
    return $unsigned(sv >>> s);
  endfunction

endpackage

@@ hw/rtl/barometric_pressure_compensation_unit.sv @@
// Top level of the barometric pressure and temperature compensation pipeline.
//
//  channel   signals                                   direction
//  --------  ----------------------------------------  ---------
//  input     start_i, busy_o, in_i                      in
//  result    result_valid_o, result_o                   out
//  config    cfg_valid_i, cfg_ready_o, cfg_index_i,     in
//            cfg_data_i
//
// One transaction is accepted every cycle; busy_o stays low. Each result passes through
// the stage registers and the two bit-per-stage dividers of DataWidth stages each.
// Reset clears the calibration words and all valid bits; payload is not reset.
// The receiver cannot stall, so the pipeline advances every cycle.
module barometric_pressure_compensation_unit import bpc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  bpc_in_t                 in_i,
  output logic                    result_valid_o,
  output bpc_out_t                result_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i
);

  localparam int unsigned W = DataWidth;
  localparam int unsigned Lat = 10 + 2 * W;

  // ---------------- calibration registers ----------------
  logic [63:0] calib_a_q, calib_b_q;
  logic [31:0] calib_c_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_a_q <= '0;
      calib_b_q <= '0;
      calib_c_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgCalibA: calib_a_q <= cfg_data_i;
        CfgCalibB: calib_b_q <= cfg_data_i;
        CfgCalibC: calib_c_q <= cfg_data_i[31:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = sx16(calib_a_q[63:48]);
  assign ac2 = sx16(calib_a_q[47:32]);
  assign ac3 = sx16(calib_a_q[31:16]);
  assign ac4 = zx16(calib_a_q[15:0]);
  assign ac5 = zx16(calib_b_q[63:48]);
  assign ac6 = zx16(calib_b_q[47:32]);
  assign b1  = sx16(calib_b_q[31:16]);
  assign b2  = sx16(calib_b_q[15:0]);
  assign mc  = sx16(calib_c_q[31:16]);
  assign md  = sx16(calib_c_q[15:0]);

  // ---------------- valid chain ----------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v11_q, v12_q, vo_q;
  logic div1_v, div2_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0;
      v11_q <= 1'b0; v12_q <= 1'b0; vo_q <= 1'b0;
    end else begin
      v1_q  <= start_i && !busy_o;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= div1_v;
      v5_q  <= v4_q;
      v6_q  <= v5_q;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v11_q <= div2_v;
      v12_q <= v11_q;
      vo_q  <= v12_q;
    end
  end

  // ---------------- stage 1: capture readings ----------------
  logic [31:0] ut1_q, up1_q;
  always_ff @(posedge clk_i) begin
    ut1_q <= zx16(in_i.raw_temperature);
    up1_q <= zx16(in_i.raw_pressure);
  end

  // ---------------- stage 2: (UT - AC6) * AC5 ----------------
  logic [31:0] p1_q, up2_q;
  always_ff @(posedge clk_i) begin
    p1_q  <= (ut1_q - ac6) * ac5;
    up2_q <= up1_q;
  end

  // ---------------- stage 3: X1, divisor, magnitudes ----------------
  logic [31:0] x1_3, div_3, num_3;
  assign x1_3  = asr32(p1_q, 15);
  assign div_3 = x1_3 + md;
  assign num_3 = mc << 11;

  typedef struct packed {
    logic [31:0] x1;
    logic [31:0] up;
    logic        neg;
    logic        err;
  } side1_t;

  side1_t      side3_q, side1_o;
  logic [31:0] mn3_q, md3_q, quo1;

  always_ff @(posedge clk_i) begin
    mn3_q       <= num_3[31] ? (32'd0 - num_3) : num_3;
    md3_q       <= div_3[31] ? (32'd0 - div_3) : div_3;
    side3_q.x1  <= x1_3;
    side3_q.up  <= up2_q;
    side3_q.neg <= num_3[31] ^ div_3[31];
    side3_q.err <= (div_3 == 32'd0);
  end

  bpc_udiv #(.W(W), .SW($bits(side1_t))) u_div_temp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .num_i   (mn3_q),
    .den_i   (md3_q),
    .side_i  (side3_q),
    .valid_o (div1_v),
    .quo_o   (quo1),
    .side_o  (side1_o)
  );

  // ---------------- stage 4: B5, temperature, B6 ----------------
  logic [31:0] x2_4, b5_4;
  assign x2_4 = side1_o.neg ? (32'd0 - quo1) : quo1;
  assign b5_4 = side1_o.x1 + x2_4;

  logic [31:0] temp4_q, b6_4_q, up4_q;
  logic        err4_q;
  always_ff @(posedge clk_i) begin
    temp4_q <= asr32(b5_4 + 32'd8, 4);
    b6_4_q  <= b5_4 - TempOffset;
    up4_q   <= side1_o.up;
    err4_q  <= side1_o.err;
  end

  // ---------------- stage 5: products on B6 ----------------
  logic [31:0] b6sq5_q, ac2b6_5_q, ac3b6_5_q, temp5_q, up5_q;
  logic        err5_q;
  always_ff @(posedge clk_i) begin
    b6sq5_q   <= b6_4_q * b6_4_q;
    ac2b6_5_q <= ac2 * b6_4_q;
    ac3b6_5_q <= ac3 * b6_4_q;
    temp5_q   <= temp4_q;
    up5_q     <= up4_q;
    err5_q    <= err4_q;
  end

  // ---------------- stage 6: products on the square ----------------
  logic [31:0] sq6;
  assign sq6 = asr32(b6sq5_q, 12);

  logic [31:0] m1_6_q, m2_6_q, ac2b6_6_q, ac3b6_6_q, temp6_q, up6_q;
  logic        err6_q;
  always_ff @(posedge clk_i) begin
    m1_6_q    <= b2 * sq6;
    m2_6_q    <= b1 * sq6;
    ac2b6_6_q <= ac2b6_5_q;
    ac3b6_6_q <= ac3b6_5_q;
    temp6_q   <= temp5_q;
    up6_q     <= up5_q;
    err6_q    <= err5_q;
  end

  // ---------------- stage 7: B3 and the B4 factor ----------------
  logic [31:0] x3a_7, x3b_7;
  assign x3a_7 = asr32(m1_6_q, 11) + asr32(ac2b6_6_q, 11);
  assign x3b_7 = asr32(asr32(ac3b6_6_q, 13) + asr32(m2_6_q, 16) + 32'd2, 2);

  logic [31:0] b3_7_q, t4_7_q, temp7_q, up7_q;
  logic        err7_q;
  always_ff @(posedge clk_i) begin
    b3_7_q  <= asr32((ac1 << 2) + x3a_7 + 32'd2, 2);
    t4_7_q  <= x3b_7 + B4Offset;
    temp7_q <= temp6_q;
    up7_q   <= up6_q;
    err7_q  <= err6_q;
  end

  // ---------------- stage 8: B4 and B7 ----------------
  logic [31:0] b4mul_8, b4_8_q, b7_8_q, temp8_q;
  logic        err8_q;
  assign b4mul_8 = ac4 * t4_7_q;
  always_ff @(posedge clk_i) begin
    b4_8_q  <= b4mul_8 >> 15;
    b7_8_q  <= (up7_q - b3_7_q) * PressScale;
    temp8_q <= temp7_q;
    err8_q  <= err7_q;
  end

  // ---------------- pressure division ----------------
  typedef struct packed {
    logic [31:0] temp;
    logic        big;
    logic        err;
  } side2_t;

  side2_t      side2_i, side2_o;
  logic [31:0] num2, quo2;

  // hold the doubling until after the divide when B7 already has its top bit set
  assign num2         = b7_8_q[31] ? b7_8_q : (b7_8_q << 1);
  assign side2_i.temp = temp8_q;
  assign side2_i.big  = b7_8_q[31];
  assign side2_i.err  = err8_q || (b4_8_q == 32'd0);

  bpc_udiv #(.W(W), .SW($bits(side2_t))) u_div_press (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v8_q),
    .num_i   (num2),
    .den_i   (b4_8_q),
    .side_i  (side2_i),
    .valid_o (div2_v),
    .quo_o   (quo2),
    .side_o  (side2_o)
  );

  // ---------------- stage 11: correction products ----------------
  logic [31:0] p10, p8_10;
  assign p10   = side2_o.big ? (quo2 << 1) : quo2;
  assign p8_10 = asr32(p10, 8);

  logic [31:0] psq11_q, lin11_q, p11_q, temp11_q;
  logic        err11_q;
  always_ff @(posedge clk_i) begin
    psq11_q  <= p8_10 * p8_10;
    lin11_q  <= PCoefLin * p10;
    p11_q    <= p10;
    temp11_q <= side2_o.temp;
    err11_q  <= side2_o.err;
  end

  // ---------------- stage 12: scale the square and linear terms ----------------
  logic [31:0] x1_12, x1_12_q, x2_12_q, p12_q, temp12_q;
  logic        err12_q;
  assign x1_12 = psq11_q * PCoefSq;
  always_ff @(posedge clk_i) begin
    x1_12_q  <= asr32(x1_12, 16);
    x2_12_q  <= asr32(lin11_q, 16);
    p12_q    <= p11_q;
    temp12_q <= temp11_q;
    err12_q  <= err11_q;
  end

  // ---------------- output stage ----------------
  logic [31:0] pfin;
  assign pfin = p12_q + asr32(x1_12_q + x2_12_q + PCoefOff, 4);

  bpc_out_t res_q;
  always_ff @(posedge clk_i) begin
    res_q.temperature_tenths <= err12_q ? '0 : $signed(temp12_q);
    res_q.pressure_pascal    <= err12_q ? '0 : $signed(pfin);
    res_q.divide_error       <= err12_q;
  end

  assign result_valid_o = vo_q;
  assign result_o       = res_q;

`ifndef SYNTHESIS
  a_err_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.divide_error |->
      result_o.pressure_pascal == 32'sd0 && result_o.temperature_tenths == 32'sd0)
    else $error("error result carries nonzero data");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(v1_q, Lat))
    else $error("result strobe does not match accepted transaction");

  a_div_temp_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div1_v |-> $past(v3_q, W))
    else $error("temperature divider lost or invented a transaction");
`endif

endmodule

@@ hw/rtl/bpc_udiv.sv @@
// Pipelined restoring unsigned divider, one quotient bit per stage.
module bpc_udiv import bpc_pkg::*; #(
  parameter int unsigned W  = DataWidth,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [W-1:0]  num_i,
  input  logic [W-1:0]  den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [W-1:0]  quo_o,
  output logic [SW-1:0] side_o
);

  logic          valid_q [W];
  logic [W-1:0]  rem_q   [W];
  logic [W-1:0]  nq_q    [W];
  logic [W-1:0]  den_q   [W];
  logic [SW-1:0] side_q  [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic          v_in;
    logic [W-1:0]  rem_in;
    logic [W-1:0]  nq_in;
    logic [W-1:0]  den_in;
    logic [SW-1:0] side_in;
    logic [W:0]    r2;
    logic [W:0]    diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign nq_in   = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = valid_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign nq_in   = nq_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    // shift in next numerator bit, subtract when it fits
    assign r2   = {rem_in, nq_in[W-1]};
    assign diff = r2 - {1'b0, den_in};
    assign ge   = ~diff[W];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? diff[W-1:0] : r2[W-1:0];
      nq_q[k]   <= {nq_in[W-2:0], ge};
      den_q[k]  <= den_in;
      side_q[k] <= side_in;
    end
  end

  assign valid_o = valid_q[W-1];
  assign quo_o   = nq_q[W-1];
  assign side_o  = side_q[W-1];

endmodule
